FILE: src/fspc_pkg.sv
// Shared types, codes and helpers for the five-stage pipeline step core.
// No dependencies; imported by every module of the block.
package fspc_pkg;

    // Instruction store depth (words), power of two.
    localparam int unsigned IMEM_DEPTH_DEF = 1024;
    // Register file is fixed at eight entries.
    localparam int unsigned RF_DEPTH = 8;
    localparam int unsigned RF_AW    = 3;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 80;

    // Request kinds carried on s_tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [5:0] {
        OP_NOOP = 6'd0,
        OP_ALU  = 6'd1,
        OP_ADDI = 6'd2,
        OP_ANDI = 6'd3,
        OP_HALT = 6'd4,
        OP_JUMP = 6'd5,
        OP_BEQ  = 6'd6
    } opcode_t;

    typedef enum logic [5:0] {
        FN_ADD = 6'd0,
        FN_SUB = 6'd1,
        FN_AND = 6'd2,
        FN_OR  = 6'd3,
        FN_XOR = 6'd4
    } funct_t;

    // One result request.
    typedef struct packed {
        logic               halted;
        logic [31:0]        cycle_count;
        logic [9:0]         program_counter;
        logic               writeback_enable;
        logic [2:0]         writeback_register;
        logic signed [31:0] writeback_value;
    } result_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic opcode_t op_of(input logic [31:0] w);
        return opcode_t'(w[31:26]);
    endfunction

endpackage

FILE: src/five_stage_pipeline_cpu_step_core.sv
// Top level of the five-stage pipeline step core: stream ports, store, pipeline, output skid.
// Depends on fspc_pkg, fspc_imem, fspc_pipe, fspc_skid.
//
//  channel | dir | tuser             | tdata (lowest bit first)
//  --------+-----+-------------------+-------------------------------------------------
//  s_      | in  | command           | load_address[9:0], instruction_word[41:10], 0 pad
//  m_      | out | -                 | halted[0], cycle_count[32:1], program_counter
//          |     |                   | [42:33], writeback_enable[43], writeback_register
//          |     |                   | [46:44], writeback_value[78:47], 0 pad
//
// One request per clock while s_tready is high: a load or a tick is handled in the cycle
// it is taken and its result is registered on the same edge, in the output register or in
// the skid if m_ is stalled. Tick rate is set by the pipeline registers plus the store's
// registered read, which always holds the word at the fetch pc. After reset the store is
// zeroed one word per cycle, with s_tready low. A stalled m_ side is absorbed by a one-deep
// skid; s_tready drops while it is full or the sweep runs. IMEM_DEPTH must be a power of two.
module five_stage_pipeline_cpu_step_core #(
    parameter int unsigned IMEM_DEPTH = fspc_pkg::IMEM_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fspc_pkg::S_TDATA_W-1:0] s_tdata,  // load_address, instruction_word
    input  logic                           s_tuser,  // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fspc_pkg::M_TDATA_W-1:0] m_tdata   // halted, cycle_count, program_counter,
                                                      // writeback_enable/_register/_value
);
    import fspc_pkg::*;

    localparam int unsigned AW = $clog2(IMEM_DEPTH);

    logic          accept, do_load, do_tick;
    logic          clr_busy, skid_ready;
    logic [9:0]    load_address;
    logic [31:0]   instruction_word;
    logic [31:0]   load_addr_wide;
    logic [AW-1:0] fetch_addr;
    logic [31:0]   fetch_word;
    result_t       res, res_out;

    assign load_address     = s_tdata[9:0];
    assign instruction_word = s_tdata[41:10];

    // no requests until the store sweep is done
    assign s_tready = skid_ready & ~clr_busy;
    assign accept   = s_tvalid & s_tready;
    assign do_load  = accept & (s_tuser == CMD_LOAD);
    assign do_tick  = accept & (s_tuser == CMD_TICK);

    // load address wraps on the store depth
    assign load_addr_wide = 32'(load_address);

    fspc_imem #(
        .IMEM_DEPTH (IMEM_DEPTH),
        .AW         (AW)
    ) u_imem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (do_load),
        .wr_addr (load_addr_wide[AW-1:0]),
        .wr_data (instruction_word),
        .rd_addr (fetch_addr),
        .rd_data (fetch_word),
        .busy    (clr_busy)
    );

    fspc_pipe #(
        .IMEM_DEPTH (IMEM_DEPTH),
        .AW         (AW)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (do_tick),
        .fetch_word (fetch_word),
        .fetch_addr (fetch_addr),
        .result     (res)
    );

    fspc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_ready  (skid_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {1'b0,
                      res_out.writeback_value,
                      res_out.writeback_register,
                      res_out.writeback_enable,
                      res_out.program_counter,
                      res_out.cycle_count,
                      res_out.halted};

endmodule

FILE: src/fspc_imem.sv
// Instruction store: single write port, one registered read port, zeroing sweep after reset.
// Depends on fspc_pkg.
module fspc_imem #(
    parameter int unsigned IMEM_DEPTH = fspc_pkg::IMEM_DEPTH_DEF,
    parameter int unsigned AW         = $clog2(IMEM_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    output logic          busy
);
    import fspc_pkg::*;

    logic [31:0]   mem [IMEM_DEPTH];
    logic [AW-1:0] clr_addr_reg;
    logic          busy_reg;
    logic [31:0]   rd_data_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    // Sweep owns the write port until every word is zero.
    assign we    = busy_reg | wr_en;
    assign waddr = busy_reg ? clr_addr_reg : wr_addr;
    assign wdata = busy_reg ? 32'd0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
            rd_data_reg  <= '0;
        end
        else
        begin
            if (busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(IMEM_DEPTH - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            // write-through so a load at the fetch address is seen next cycle
            if (we && (waddr == rd_addr))
            begin
                rd_data_reg <= wdata;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

FILE: src/fspc_pipe.sv
// Pipeline state (IF/ID, ID/EX, EX/MEM, MEM/WB), register file and one-tick next-state logic.
// Depends on fspc_pkg; fetch word comes from fspc_imem.
module fspc_pipe #(
    parameter int unsigned IMEM_DEPTH = fspc_pkg::IMEM_DEPTH_DEF,
    parameter int unsigned AW         = $clog2(IMEM_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick,
    input  logic [31:0]       fetch_word,
    output logic [AW-1:0]     fetch_addr,
    output fspc_pkg::result_t result
);
    import fspc_pkg::*;

    logic [AW-1:0] fetch_pc_reg;
    logic [31:0]   ifid_instr_reg;
    logic [10:0]   ifid_next_pc_reg;
    logic [31:0]   idex_instr_reg, idex_a_reg, idex_b_reg, idex_imm_reg;
    logic [31:0]   exmem_instr_reg, exmem_target_reg, exmem_alu_reg;
    logic          exmem_take_reg;
    logic [31:0]   memwb_instr_reg, memwb_value_reg;
    logic [31:0]   tick_count_reg;
    logic          halt_reg;
    logic [31:0]   rf_reg [RF_DEPTH];

    logic          active;
    logic [31:0]   pc_inc;
    logic [AW-1:0] pc_next;
    logic [31:0]   id_imm_next;
    opcode_t       id_op, ex_op, wb_op;
    logic          take_next;
    logic [31:0]   target_next, alu_next, br_sum;
    logic          wb_en;
    logic [RF_AW-1:0] wb_reg;
    logic [31:0]   count_next;
    logic          halt_next;
    logic [31:0]   pc_out_wide;

    assign active = tick & ~halt_reg;

    // fetch
    assign pc_inc  = 32'(fetch_pc_reg) + 32'd1;
    assign pc_next = exmem_take_reg ? exmem_target_reg[AW-1:0] : pc_inc[AW-1:0];

    // decode: only beq sign-extends
    assign id_op       = op_of(ifid_instr_reg);
    assign id_imm_next = (id_op == OP_BEQ) ? sext16(ifid_instr_reg[15:0])
                                           : {16'd0, ifid_instr_reg[15:0]};

    // execute
    assign ex_op  = op_of(idex_instr_reg);
    assign br_sum = {21'd0, ifid_next_pc_reg} + sext16(idex_imm_reg[15:0]);

    always_comb
    begin
        take_next   = 1'b0;
        target_next = exmem_target_reg;
        alu_next    = exmem_alu_reg;
        unique case (ex_op)
            OP_ALU:
            begin
                case (funct_t'(idex_instr_reg[5:0]))
                    FN_ADD:  alu_next = idex_a_reg + idex_b_reg;
                    FN_SUB:  alu_next = idex_a_reg - idex_b_reg;
                    FN_AND:  alu_next = idex_a_reg & idex_b_reg;
                    FN_OR:   alu_next = idex_a_reg | idex_b_reg;
                    FN_XOR:  alu_next = idex_a_reg ^ idex_b_reg;
                    default: alu_next = exmem_alu_reg;
                endcase
            end
            OP_ADDI: alu_next = idex_a_reg + idex_imm_reg;
            OP_ANDI: alu_next = idex_a_reg & idex_imm_reg;
            OP_JUMP:
            begin
                take_next   = 1'b1;
                target_next = br_sum;
            end
            OP_BEQ:
            begin
                take_next   = (idex_a_reg == idex_b_reg);
                target_next = br_sum;
            end
            default: alu_next = '0;
        endcase
    end

    // writeback
    assign wb_op  = op_of(memwb_instr_reg);
    assign wb_en  = (wb_op != OP_NOOP) && (wb_op != OP_BEQ) && (wb_op != OP_JUMP);
    assign wb_reg = (wb_op == OP_ALU) ? memwb_instr_reg[13:11] : memwb_instr_reg[18:16];

    assign count_next = tick_count_reg + 32'd1;
    assign halt_next  = (op_of(exmem_instr_reg) == OP_HALT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_pc_reg     <= '0;
            ifid_instr_reg   <= '0;
            ifid_next_pc_reg <= '0;
            idex_instr_reg   <= '0;
            idex_a_reg       <= '0;
            idex_b_reg       <= '0;
            idex_imm_reg     <= '0;
            exmem_instr_reg  <= '0;
            exmem_target_reg <= '0;
            exmem_alu_reg    <= '0;
            exmem_take_reg   <= 1'b0;
            memwb_instr_reg  <= '0;
            memwb_value_reg  <= '0;
            tick_count_reg   <= '0;
            halt_reg         <= 1'b0;
            for (int i = 0; i < RF_DEPTH; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (active)
        begin
            fetch_pc_reg     <= pc_next;
            ifid_instr_reg   <= fetch_word;
            ifid_next_pc_reg <= pc_inc[10:0];
            idex_instr_reg   <= ifid_instr_reg;
            idex_a_reg       <= rf_reg[ifid_instr_reg[23:21]];
            idex_b_reg       <= rf_reg[ifid_instr_reg[18:16]];
            idex_imm_reg     <= id_imm_next;
            exmem_instr_reg  <= idex_instr_reg;
            exmem_take_reg   <= take_next;
            exmem_target_reg <= target_next;
            exmem_alu_reg    <= alu_next;
            memwb_instr_reg  <= exmem_instr_reg;
            memwb_value_reg  <= exmem_alu_reg;
            tick_count_reg   <= count_next;
            halt_reg         <= halt_next;
            if (wb_en)
            begin
                rf_reg[wb_reg] <= memwb_value_reg;
            end
        end
    end

    // address the store will hold in front of fetch after this cycle
    assign fetch_addr  = active ? pc_next : fetch_pc_reg;
    assign pc_out_wide = 32'(fetch_addr);

    always_comb
    begin
        result.halted             = active ? halt_next : halt_reg;
        result.cycle_count        = active ? count_next : tick_count_reg;
        result.program_counter    = pc_out_wide[9:0];
        result.writeback_enable   = active & wb_en;
        result.writeback_register = (active & wb_en) ? wb_reg : 3'd0;
        result.writeback_value    = (active & wb_en) ? memwb_value_reg : 32'sd0;
    end

endmodule

FILE: src/fspc_skid.sv
// Output register with skid stage for result requests.
// Depends on fspc_pkg.
module fspc_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fspc_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fspc_pkg::result_t out_data
);
    import fspc_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    take;

    assign in_ready = ~skid_valid_reg;
    assign take     = in_valid & ~skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (take)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (take)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
